/* hw/rtl/mf3_pkg.sv */
package mf3_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 2048;
  localparam int unsigned CFG_W         = 12;
  localparam int unsigned CHAN_W        = 8;
  localparam int unsigned PIX_W         = 3 * CHAN_W;
  localparam int unsigned WIN_TAPS      = 9;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;
  localparam logic [CFG_W-1:0] MIN_DIM    = 12'd3;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // item kinds on tuser
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [PIX_W-1:0]  pix_t;

  function automatic chan_t min2(input chan_t a, input chan_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic chan_t max2(input chan_t a, input chan_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic chan_t min3(input chan_t a, input chan_t b, input chan_t c);
    return min2(min2(a, b), c);
  endfunction

  function automatic chan_t max3(input chan_t a, input chan_t b, input chan_t c);
    return max2(max2(a, b), c);
  endfunction

  function automatic chan_t med3(input chan_t a, input chan_t b, input chan_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

endpackage

/* hw/rtl/median_3x3_filter.sv */
// Pipeline: stage 1, window snapshot, row sort, median candidates, output register;
//   results trail the input by frame_width+1 items. Throughput: one item per cycle
//   unless the output stalls, set by the single read-modify-write of the line memory.
// Reset: frame 640 x 480, position counters and 3x3 window cleared, pipeline emptied.
//   The line memory is not cleared; entries are written before any result uses them.
module median_3x3_filter #(
  parameter int unsigned MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [mf3_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [mf3_pkg::PIX_W-1:0] s_axis_tdata,  // chan0, chan1, chan2
  input  logic                     s_axis_tuser,  // cmd
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [mf3_pkg::PIX_W-1:0] m_axis_tdata,  // out_chan0, out_chan1, out_chan2
  output logic                     m_axis_tlast   // frame_end
);
  import mf3_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W  = ADDR_W + 1;
  localparam int unsigned ROW_W  = CFG_W + 1;
  localparam int unsigned MEM_W  = CHAN_W + PIX_W;

  // configuration
  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic [WID_W-1:0] eff_w;
  logic [CFG_W-1:0] eff_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WIDTH_RST;
      frame_height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else if (frame_width_q < MIN_DIM) begin
      eff_w = WID_W'(MIN_DIM);
    end else begin
      eff_w = WID_W'(frame_width_q);
    end
    eff_h = (frame_height_q < MIN_DIM) ? MIN_DIM : frame_height_q;
  end

  // input side
  logic              en, acc, in_done, drop, in_emit, in_wrap;
  logic [ADDR_W-1:0] in_col_q;
  logic [ROW_W-1:0]  in_row_q;
  logic [WID_W-1:0]  in_col_inc;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && en;
  assign in_done       = in_row_q >= {1'b0, eff_h};
  assign drop          = (s_axis_tuser == CMD_FLUSH) && !in_done;
  assign in_emit       = (in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && (in_col_q != '0));
  assign in_col_inc    = {1'b0, in_col_q} + WID_W'(1);
  // this item produces the frame-end result, so the next one starts a new frame
  assign in_wrap       = (in_row_q == ({1'b0, eff_h} + ROW_W'(1))) && (in_col_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
    end else if (cfg_we_i) begin
      in_col_q <= '0;
      in_row_q <= '0;
    end else if (acc && !drop) begin
      if (in_wrap) begin
        in_col_q <= '0;
        in_row_q <= '0;
      end else if (in_col_inc >= eff_w) begin
        in_col_q <= '0;
        in_row_q <= in_row_q + ROW_W'(1);
      end else begin
        in_col_q <= in_col_inc[ADDR_W-1:0];
      end
    end
  end

  // stage 1: line memory read data arrives
  logic              s1_valid_q, s1_emit_q;
  pix_t              s1_pix_q;
  logic [ADDR_W-1:0] s1_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= acc && !drop;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_pix_q  <= in_done ? '0 : s_axis_tdata;
      s1_col_q  <= in_col_q;
      s1_emit_q <= in_emit;
    end
  end

  // line memory: entry = {upper channel 0, middle pixel}
  logic [MEM_W-1:0] line_mem [MAX_WIDTH];
  logic [MEM_W-1:0] rd_q;
  chan_t            line_a;
  pix_t             line_b;
  logic             wr_en;

  assign line_a = rd_q[MEM_W-1:PIX_W];
  assign line_b = rd_q[PIX_W-1:0];
  assign wr_en  = s1_valid_q && en;

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rd_q <= line_mem[in_col_q];
    end
    if (wr_en) begin
      line_mem[s1_col_q] <= {line_b[CHAN_W-1:0], s1_pix_q};
    end
  end

  // window, center pixel and output position
  chan_t             win_q [WIN_TAPS];
  chan_t             win_d [WIN_TAPS];
  pix_t              center_q;
  logic [ADDR_W-1:0] out_col_q;
  logic [CFG_W-1:0]  out_row_q;
  logic [WID_W-1:0]  out_col_inc;
  logic [ROW_W-1:0]  out_row_inc;
  logic              interior, last;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3]   = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
    end
    win_d[2] = line_a;
    win_d[5] = line_b[CHAN_W-1:0];
    win_d[8] = s1_pix_q[CHAN_W-1:0];
  end

  assign out_col_inc = {1'b0, out_col_q} + WID_W'(1);
  assign out_row_inc = {1'b0, out_row_q} + ROW_W'(1);
  assign interior    = (out_row_q != '0) && (out_row_inc < {1'b0, eff_h}) &&
                       (out_col_q != '0) && (out_col_inc < eff_w);
  assign last        = (out_row_inc >= {1'b0, eff_h}) && (out_col_inc >= eff_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_TAPS; i++) begin
        win_q[i] <= '0;
      end
      center_q <= '0;
    end else if (wr_en) begin
      win_q    <= win_d;
      center_q <= line_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (cfg_we_i) begin
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (wr_en && s1_emit_q) begin
      if (last) begin
        out_col_q <= '0;
        out_row_q <= '0;
      end else if (out_col_inc >= eff_w) begin
        out_col_q <= '0;
        out_row_q <= out_row_inc[CFG_W-1:0];
      end else begin
        out_col_q <= out_col_inc[ADDR_W-1:0];
      end
    end
  end

  // stage 2: window snapshot
  logic  s2_valid_q, s2_border_q, s2_last_q;
  pix_t  s2_prev_q;
  chan_t s2_win_q [WIN_TAPS];

  // stage 3: rows sorted
  logic  s3_valid_q, s3_border_q, s3_last_q;
  pix_t  s3_prev_q;
  chan_t s3_lo_q [3];
  chan_t s3_mid_q [3];
  chan_t s3_hi_q [3];

  // stage 4: three median candidates
  logic  s4_valid_q, s4_border_q, s4_last_q;
  pix_t  s4_prev_q;
  chan_t s4_lo_q, s4_mid_q, s4_hi_q;

  chan_t med;
  assign med = med3(s4_lo_q, s4_mid_q, s4_hi_q);

  // output register
  pix_t m_data_q;
  logic m_valid_q, m_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q && s1_emit_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      m_valid_q  <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_win_q    <= win_d;
      s2_border_q <= !interior;
      s2_last_q   <= last;
      s2_prev_q   <= center_q;

      for (int r = 0; r < 3; r++) begin
        s3_lo_q[r]  <= min3(s2_win_q[r*3], s2_win_q[r*3+1], s2_win_q[r*3+2]);
        s3_mid_q[r] <= med3(s2_win_q[r*3], s2_win_q[r*3+1], s2_win_q[r*3+2]);
        s3_hi_q[r]  <= max3(s2_win_q[r*3], s2_win_q[r*3+1], s2_win_q[r*3+2]);
      end
      s3_border_q <= s2_border_q;
      s3_last_q   <= s2_last_q;
      s3_prev_q   <= s2_prev_q;

      s4_lo_q     <= max3(s3_lo_q[0], s3_lo_q[1], s3_lo_q[2]);
      s4_mid_q    <= med3(s3_mid_q[0], s3_mid_q[1], s3_mid_q[2]);
      s4_hi_q     <= min3(s3_hi_q[0], s3_hi_q[1], s3_hi_q[2]);
      s4_border_q <= s3_border_q;
      s4_last_q   <= s3_last_q;
      s4_prev_q   <= s3_prev_q;

      m_data_q    <= s4_border_q ? s4_prev_q : {med, med, med};
      m_last_q    <= s4_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  // an early flush leaves no trace in the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (s_axis_tuser == CMD_FLUSH) && !in_done && !cfg_we_i) |=> !s1_valid_q)
    else $error("early flush entered the pipeline");

  // input column stays inside the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, in_col_q} < eff_w)
    else $error("input column beyond frame width");

  // the frame-end result returns the output position to the origin
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && s1_emit_q && last) |=> (out_col_q == '0) && (out_row_q == '0))
    else $error("output position not cleared at frame end");

  // a frame-end result is always marked when it enters stage 2
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && s1_emit_q && last) |=> s2_valid_q && s2_last_q)
    else $error("frame end lost between stages");

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import mf3_pkg::*;

  localparam int unsigned MAX_W       = MAX_WIDTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned RAND_ITEMS  = 160;

  typedef struct packed {
    chan_t c0;
    chan_t c1;
    chan_t c2;
    logic  last;
  } out_pix_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic              cfg_idx_i     = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [PIX_W-1:0]  s_axis_tdata  = '0;  // chan0, chan1, chan2
  logic              s_axis_tuser  = CMD_PIXEL;  // cmd
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [PIX_W-1:0]  m_axis_tdata;  // out_chan0, out_chan1, out_chan2
  logic              m_axis_tlast;  // frame_end

  // predictor state
  logic [CFG_W-1:0]  frame_w_reg;
  logic [CFG_W-1:0]  frame_h_reg;
  chan_t             upper_mem [MAX_W];
  pix_t              middle_mem [MAX_W];
  chan_t             win [WIN_TAPS];
  pix_t              center_pix_q;
  int unsigned       in_col, in_row, out_col, out_row;
  out_pix_t          filtered_q [$];

  bit                idle_on;
  bit                long_hold_req;
  int unsigned       stall_left;
  int unsigned       err_count;
  int unsigned       result_count;
  int unsigned       cycle_count;

  median_3x3_filter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned eff_width(input logic [CFG_W-1:0] v);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > MAX_W) return MAX_W;
    return v;
  endfunction

  function automatic int unsigned eff_height(input logic [CFG_W-1:0] v);
    return (v < MIN_DIM) ? MIN_DIM : v;
  endfunction

  // rank selection: the median has at most four smaller taps and at least five not larger
  function automatic chan_t window_median();
    int below, not_above;
    for (int i = 0; i < WIN_TAPS; i++) begin
      below = 0;
      not_above = 0;
      for (int j = 0; j < WIN_TAPS; j++) begin
        if (win[j] < win[i]) below++;
        if (win[j] <= win[i]) not_above++;
      end
      if (below <= 4 && not_above >= 5) return win[i];
    end
    return '0;
  endfunction

  function automatic pix_t rand_pixel();
    pix_t p;
    p = pix_t'($urandom());
    // crowd channel 0 into a few values so ties show up in the window
    if ($urandom_range(0, 3) == 0) p[CHAN_W-1:0] = chan_t'($urandom_range(0, 3));
    return p;
  endfunction

  task automatic clear_positions();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endtask

  task automatic reset_model();
    frame_w_reg = WIDTH_RST;
    frame_h_reg = HEIGHT_RST;
    for (int i = 0; i < MAX_W; i++) begin
      upper_mem[i]  = '0;
      middle_mem[i] = '0;
    end
    for (int i = 0; i < WIN_TAPS; i++) win[i] = '0;
    center_pix_q = '0;
    clear_positions();
  endtask

  task automatic filter_item(input logic cmd, input pix_t pix);
    int unsigned w, h, col;
    chan_t       up, med;
    pix_t        mid, prev, cur;
    bit          emit;
    out_pix_t    res;
    w = eff_width(frame_w_reg);
    h = eff_height(frame_h_reg);
    // flush before the frame is complete: ignored
    if (cmd == CMD_FLUSH && in_row * w + in_col < w * h) return;
    cur = (in_row * w + in_col >= w * h) ? '0 : pix;
    col = in_col;
    up  = upper_mem[col];
    mid = middle_mem[col];
    upper_mem[col]  = mid[CHAN_W-1:0];
    middle_mem[col] = cur;
    for (int r = 0; r < 3; r++) begin
      win[3*r]   = win[3*r+1];
      win[3*r+1] = win[3*r+2];
    end
    win[2] = up;
    win[5] = mid[CHAN_W-1:0];
    win[8] = cur[CHAN_W-1:0];
    prev = center_pix_q;
    center_pix_q = mid;
    emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!emit) return;
    if (out_row >= 1 && out_row + 1 < h && out_col >= 1 && out_col + 1 < w) begin
      med = window_median();
      res.c0 = med;
      res.c1 = med;
      res.c2 = med;
    end else begin
      res.c0 = prev[CHAN_W-1:0];
      res.c1 = prev[2*CHAN_W-1:CHAN_W];
      res.c2 = prev[3*CHAN_W-1:2*CHAN_W];
    end
    res.last = (out_row + 1 >= h && out_col + 1 >= w);
    if (res.last) begin
      clear_positions();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
    filtered_q.push_back(res);
  endtask

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got)
      flag_error($sformatf("result %0d %s: expected %0h, got %0h",
                           result_count, name, want, got));
  endtask

  // valid stays high from one transfer to the next unless a gap is inserted
  task automatic send_item(input logic cmd, input pix_t pix);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    filter_item(cmd, pix);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic configure(input logic [CFG_W-1:0] width, input logic [CFG_W-1:0] height);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_FRAME_WIDTH;
    cfg_wdata_i <= width;
    @(posedge clk_i);
    cfg_idx_i   <= REG_FRAME_HEIGHT;
    cfg_wdata_i <= height;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    frame_w_reg = width;
    frame_h_reg = height;
    clear_positions();
  endtask

  // n_pix below w*h leaves the frame open; a full frame is drained with w+1 items
  task automatic send_frame(input int unsigned w, input int unsigned h,
                            input int unsigned n_pix, input bit noisy,
                            output int unsigned n_items);
    n_items = 0;
    for (int unsigned i = 0; i < n_pix; i++) begin
      if (noisy && $urandom_range(0, 24) == 0) send_item(CMD_FLUSH, rand_pixel());
      send_item(CMD_PIXEL, rand_pixel());
      n_items++;
    end
    if (n_pix == w * h) begin
      for (int unsigned i = 0; i <= w; i++) begin
        // surplus pixels drain just like flush items
        send_item((noisy && $urandom_range(0, 3) == 0) ? CMD_PIXEL : CMD_FLUSH, rand_pixel());
        n_items++;
      end
      // lands at the start of the next frame and is dropped
      if (noisy && $urandom_range(0, 3) == 0) send_item(CMD_FLUSH, rand_pixel());
    end
  endtask

  task automatic test_reset_geometry();
    int unsigned n;
    send_frame(eff_width(frame_w_reg), eff_height(frame_h_reg),
               eff_width(frame_w_reg) + 10, 1'b0, n);
    wait_idle();
  endtask

  task automatic test_directed_corners();
    pix_t pix_set [9];
    pix_set = '{24'hFFFFFF, 24'h000000, 24'h80FF01, 24'h7F00FE, 24'h55AA80,
                24'hAA557F, 24'h0F0FF0, 24'hF0F00F, 24'h123400};
    // zero width and height both clamp to 3
    configure('0, '0);
    for (int i = 0; i < 4; i++) send_item(CMD_PIXEL, pix_set[i]);
    send_item(CMD_FLUSH, 24'hFFFFFF);
    for (int i = 4; i < 9; i++) send_item(CMD_PIXEL, pix_set[i]);
    send_item(CMD_PIXEL, 24'hFFFFFF);
    repeat (3) send_item(CMD_FLUSH, 24'h000000);
    send_item(CMD_FLUSH, 24'hA5A5A5);
    wait_idle();
  endtask

  task automatic test_dimension_limits();
    int unsigned n;
    configure(12'd1, 12'd2);
    send_frame(3, 3, 9, 1'b1, n);
    wait_idle();
    // tallest frame, abandoned after twenty rows by the next register write
    configure(12'd2, 12'hFFF);
    send_frame(3, eff_height(12'hFFF), 60, 1'b1, n);
    wait_idle();
  endtask

  task automatic test_backpressure();
    int unsigned n;
    configure(12'd8, 12'd6);
    long_hold_req = 1'b1;
    send_frame(8, 6, 8 * 6, 1'b0, n);
    wait_idle();
  endtask

  task automatic test_random_frames();
    int unsigned sent, n, w, h, n_pix;
    logic [CFG_W-1:0] wreg, hreg;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      if (sent >= RAND_ITEMS / 2) idle_on = 1'b0;
      case ($urandom_range(0, 9))
        0:       wreg = CFG_W'($urandom_range(0, 2));
        1:       wreg = CFG_W'($urandom_range(17, 20));
        default: wreg = CFG_W'($urandom_range(3, 12));
      endcase
      hreg = ($urandom_range(0, 7) == 0) ? CFG_W'($urandom_range(0, 2))
                                         : CFG_W'($urandom_range(3, 6));
      configure(wreg, hreg);
      w = eff_width(wreg);
      h = eff_height(hreg);
      n_pix = w * h;
      if ($urandom_range(0, 7) == 0) n_pix = $urandom_range(1, n_pix - 1);
      send_frame(w, h, n_pix, 1'b1, n);
      sent += n;
      wait_idle();
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = LONG_HOLD;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 11);
      end
    end
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    out_pix_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (filtered_q.size() == 0) begin
        flag_error($sformatf("result %0d arrived with nothing pending, data %0h last %0b",
                             result_count, m_axis_tdata, m_axis_tlast));
      end else begin
        want = filtered_q.pop_front();
        check_field("out_chan0", want.c0, m_axis_tdata[CHAN_W-1:0]);
        check_field("out_chan1", want.c1, m_axis_tdata[2*CHAN_W-1:CHAN_W]);
        check_field("out_chan2", want.c2, m_axis_tdata[3*CHAN_W-1:2*CHAN_W]);
        check_field("frame_end", want.last, m_axis_tlast);
      end
      result_count++;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("median_3x3_filter verification failed");
    $finish;
  end

  initial begin
    err_count     = 0;
    result_count  = 0;
    stall_left    = 0;
    long_hold_req = 1'b0;
    idle_on       = 1'b0;
    reset_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b1;
    test_reset_geometry();
    test_directed_corners();
    test_dimension_limits();
    test_backpressure();
    test_random_frames();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("median_3x3_filter verification clean");
    end else begin
      $display("median_3x3_filter verification failed");
    end
    $finish;
  end

endmodule
